### hdl/frustum_visibility_test_macros.svh
// ----------------------------------------------------------------------------
// frustum visibility test assertion macros
// concurrent checks clocked on aclk, held off during reset, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_VISIBILITY_TEST_MACROS_SVH
`define FRUSTUM_VISIBILITY_TEST_MACROS_SVH

`ifndef SYNTHESIS

// consequent checked in the same cycle
`define FVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FVT_ASSERT_NOW(label, ante, cons, msg)
`define FVT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hdl/fvt_pkg.sv
// ----------------------------------------------------------------------------
// fvt_pkg
// types and codes shared by the frustum visibility test modules
// ----------------------------------------------------------------------------
`default_nettype none

package fvt_pkg;

    // item kinds carried in tuser
    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_POINT  = 3'd1;
    localparam logic [2:0] KIND_BOX    = 3'd2;
    localparam logic [2:0] KIND_CUBE   = 3'd3;
    localparam logic [2:0] KIND_SPHERE = 3'd4;
    localparam logic [2:0] KIND_RECT   = 3'd5;

    // stream widths
    localparam int S_TDATA_W = 328;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // coordinate width after corner forming
    localparam int COORD_W = 33;

    // one plane: normal in q2.30, offset in q16.16
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } fvt_plane_t;

    // an item as it travels along the chain
    // lo3/hi3 hold the per-axis minimum and maximum once prepared
    typedef struct packed {
        logic                      vis;
        logic                      is_load;
        logic [2:0]                slot;
        fvt_plane_t                plane;
        logic [31:0]               extra;
        logic [2:0][COORD_W-1:0]   lo3;
        logic [2:0][COORD_W-1:0]   hi3;
    } fvt_item_t;

endpackage

`default_nettype wire

### hdl/frustum_visibility_test.sv
// ----------------------------------------------------------------------------
// frustum_visibility_test
// six-plane view frustum culling: a chain of plane cells tests one bound a beat
// ----------------------------------------------------------------------------
//  channel  direction  tdata                           tuser
//  s_       in         plane_slot, planes, bounds      kind
//  m_       out        visible                         -
//
//  one beat accepted per cycle unless m_ stalls; each plane cell registers
//  a multiply stage, then a sum and sign stage
//  after reset the planes are all zero and the chain is empty
//  stalls on m_ propagate stage by stage; empty stages still take beats
//  a plane load travels the chain in order, so later queries see it
// ----------------------------------------------------------------------------
`default_nettype none
`include "frustum_visibility_test_macros.svh"

module frustum_visibility_test #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // plane_slot, normal_a, normal_b, normal_c, offset_d, first_x, first_y,
    // first_z, second_x, second_y, second_z, zero fill
    input  wire logic [fvt_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [fvt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // visible, zero fill
    output logic [fvt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import fvt_pkg::*;

    logic      chain_valid [PLANE_COUNT+1];
    logic      chain_ready [PLANE_COUNT+1];
    fvt_item_t chain_item  [PLANE_COUNT+1];

    // beat unpacking and extent ordering
    fvt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0]),
        .out_ready (chain_ready[0])
    );

    // one cell per plane
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        fvt_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    // result beat straight from the last cell's register
    assign chain_ready[PLANE_COUNT] = m_tready;
    assign m_tvalid = chain_valid[PLANE_COUNT];
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, chain_item[PLANE_COUNT].vis};

    // checks
    `FVT_ASSERT_NOW(a_load_not_visible, m_tvalid && chain_item[PLANE_COUNT].is_load, !m_tdata[0], "load reported visible")

endmodule

`default_nettype wire

### hdl/fvt_front.sv
// ----------------------------------------------------------------------------
// fvt_front
// unpacks an input beat, forms the box extents and orders them per axis
// ----------------------------------------------------------------------------
`default_nettype none

module fvt_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fvt_pkg::S_TDATA_W-1:0] in_data,
    input  wire logic [fvt_pkg::S_TUSER_W-1:0] in_user,
    output logic                               out_valid,
    output fvt_pkg::fvt_item_t                 out_item,
    input  wire logic                          out_ready
);
    import fvt_pkg::*;

    logic      one_valid_reg, one_valid_next;
    fvt_item_t one_item_reg, one_item_next;
    logic      two_valid_reg, two_valid_next;
    fvt_item_t two_item_reg, two_item_next;
    logic      one_ready, two_ready;

    logic [2:0]                 kind;
    logic signed [COORD_W-1:0]  f3 [3];
    logic signed [COORD_W-1:0]  s3 [3];
    logic signed [COORD_W-1:0]  rad;

    // bubble-collapsing handshake
    assign two_ready = !two_valid_reg || out_ready;
    assign one_ready = !one_valid_reg || two_ready;
    assign in_ready  = one_ready;

    // field decode and corner forming
    always_comb begin
        kind   = in_user[2:0];
        rad    = COORD_W'($signed(in_data[258:227]));
        f3[0]  = COORD_W'($signed(in_data[162:131]));
        f3[1]  = COORD_W'($signed(in_data[194:163]));
        f3[2]  = COORD_W'($signed(in_data[226:195]));
        s3[0]  = COORD_W'($signed(in_data[258:227]));
        s3[1]  = COORD_W'($signed(in_data[290:259]));
        s3[2]  = COORD_W'($signed(in_data[322:291]));

        one_item_next.is_load = (kind == KIND_LOAD);
        one_item_next.vis     = (kind == KIND_POINT) || (kind == KIND_BOX) ||
                                (kind == KIND_CUBE) || (kind == KIND_SPHERE) ||
                                (kind == KIND_RECT);
        one_item_next.slot    = in_data[2:0];
        one_item_next.plane.a = in_data[34:3];
        one_item_next.plane.b = in_data[66:35];
        one_item_next.plane.c = in_data[98:67];
        one_item_next.plane.d = in_data[130:99];
        one_item_next.extra   = (kind == KIND_SPHERE) ? in_data[258:227] : 32'd0;

        for (int j = 0; j < 3; j++) begin
            case (kind)
                KIND_BOX: begin
                    one_item_next.lo3[j] = f3[j];
                    one_item_next.hi3[j] = s3[j];
                end
                KIND_CUBE: begin
                    one_item_next.lo3[j] = f3[j] - rad;
                    one_item_next.hi3[j] = f3[j] + rad;
                end
                KIND_RECT: begin
                    one_item_next.lo3[j] = f3[j] - s3[j];
                    one_item_next.hi3[j] = f3[j] + s3[j];
                end
                default: begin
                    one_item_next.lo3[j] = f3[j];
                    one_item_next.hi3[j] = f3[j];
                end
            endcase
        end
    end

    // order each axis so lo3 is the minimum and hi3 the maximum
    always_comb begin
        two_item_next = one_item_reg;
        for (int j = 0; j < 3; j++) begin
            if ($signed(one_item_reg.hi3[j]) < $signed(one_item_reg.lo3[j])) begin
                two_item_next.lo3[j] = one_item_reg.hi3[j];
                two_item_next.hi3[j] = one_item_reg.lo3[j];
            end
        end
    end

    assign one_valid_next = one_ready ? in_valid : one_valid_reg;
    assign two_valid_next = two_ready ? one_valid_reg : two_valid_reg;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_valid_reg <= 1'b0;
            two_valid_reg <= 1'b0;
        end else begin
            one_valid_reg <= one_valid_next;
            two_valid_reg <= two_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (one_ready) begin
            one_item_reg <= one_item_next;
        end
        if (two_ready) begin
            two_item_reg <= two_item_next;
        end
    end

    assign out_valid = two_valid_reg;
    assign out_item  = two_item_reg;

endmodule

`default_nettype wire

### hdl/fvt_cell.sv
// ----------------------------------------------------------------------------
// fvt_cell
// one plane of the chain: holds the plane, tests each passing item against it
// ----------------------------------------------------------------------------
`default_nettype none
`include "frustum_visibility_test_macros.svh"

module fvt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fvt_pkg::fvt_item_t in_item,
    output logic                    out_valid,
    output fvt_pkg::fvt_item_t      out_item,
    input  wire logic               out_ready
);
    import fvt_pkg::*;

    localparam logic [2:0] SLOT = CELL_INDEX[2:0];

    fvt_plane_t plane_reg, plane_next;

    logic               a_valid_reg, a_valid_next;
    fvt_item_t          a_item_reg;
    logic signed [64:0] a_prod_reg [3];
    logic signed [32:0] a_de_reg;
    logic               b_valid_reg, b_valid_next;
    fvt_item_t          b_item_reg, b_item_next;
    logic               a_ready, b_ready;
    logic               a_load, b_load, plane_wr;

    logic signed [31:0]      norm [3];
    logic signed [32:0]      coord [3];
    logic signed [64:0]      prod [3];
    logic signed [32:0]      de;
    logic signed [67:0]      distance;

    // handshake
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_load   = in_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;

    // a load beat for this slot replaces the plane as it enters
    assign plane_wr   = a_load && in_item.is_load && (in_item.slot == SLOT);
    assign plane_next = plane_wr ? in_item.plane : plane_reg;

    // pick the corner farthest along the normal, then the three products
    always_comb begin
        norm[0] = $signed(plane_reg.a);
        norm[1] = $signed(plane_reg.b);
        norm[2] = $signed(plane_reg.c);
        for (int j = 0; j < 3; j++) begin
            coord[j] = norm[j][31] ? $signed(in_item.lo3[j]) : $signed(in_item.hi3[j]);
            prod[j]  = norm[j] * coord[j];
        end
        de = 33'($signed(plane_reg.d)) + 33'($signed(in_item.extra));
    end

    // signed distance, offset aligned by 30 bits
    always_comb begin
        distance = 68'(a_prod_reg[0]) + 68'(a_prod_reg[1]) + 68'(a_prod_reg[2]) +
                   (68'(a_de_reg) <<< 30);
        b_item_next     = a_item_reg;
        b_item_next.vis = a_item_reg.vis && !distance[67];
    end

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // control state and the stored plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            plane_reg   <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            plane_reg   <= plane_next;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_item_reg <= in_item;
            a_de_reg   <= de;
            for (int j = 0; j < 3; j++) begin
                a_prod_reg[j] <= prod[j];
            end
        end
        if (b_load) begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    // checks
    `FVT_ASSERT_NEXT(a_plane_write, plane_wr, plane_reg == $past(in_item.plane), "plane load lost")
    `FVT_ASSERT_NEXT(a_vis_no_rise, b_load && !a_item_reg.vis, !b_item_reg.vis, "vis rose in cell")

endmodule

`default_nettype wire

### verif/fvt_visibility_checker.sv
// ----------------------------------------------------------------------------
// fvt_visibility_checker
// watches both stream channels, keeps its own plane table, predicts the
// visible flag of every accepted input beat and compares it with the results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvt_visibility_checker #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // plane_slot, normal_a, normal_b, normal_c, offset_d, first_x, first_y,
    // first_z, second_x, second_y, second_z, zero fill
    input  logic [fvt_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [fvt_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // visible, zero fill
    input  logic [fvt_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending
);
    import fvt_pkg::*;

    fvt_plane_t frustum_planes [PLANE_COUNT];
    bit         expected_visible [$];
    int         errs = 0;
    bit         want;

    // sign extend a 32-bit field to the accumulator width
    function automatic logic signed [71:0] widen(logic [31:0] v);
        widen = {{40{v[31]}}, v};
    endfunction

    // exact signed distance a*x + b*y + c*z + (d + extra) * 2^30 is not negative
    function automatic logic side_ok(int idx, logic signed [71:0] x, y, z, extra);
        logic signed [71:0] acc;
        acc = widen(frustum_planes[idx].a) * x + widen(frustum_planes[idx].b) * y
            + widen(frustum_planes[idx].c) * z
            + ((widen(frustum_planes[idx].d) + extra) <<< 30);
        return ~acc[71];
    endfunction

    // expected visible flag of one input beat; plane loads update the table
    function automatic logic cull_predict(logic [2:0] kind, logic [S_TDATA_W-1:0] data);
        logic signed [71:0] f  [3];
        logic signed [71:0] s  [3];
        logic signed [71:0] lo [3];
        logic signed [71:0] hi [3];
        logic [2:0]         slot;
        logic               vis;
        logic               hit;
        int                 i;
        int                 j;
        int                 k;
        slot = data[2:0];
        vis  = 1'b0;
        case (kind)
            KIND_LOAD: begin
                if (slot < PLANE_COUNT) begin
                    frustum_planes[slot].a = data[34:3];
                    frustum_planes[slot].b = data[66:35];
                    frustum_planes[slot].c = data[98:67];
                    frustum_planes[slot].d = data[130:99];
                end
            end
            KIND_POINT, KIND_BOX, KIND_CUBE, KIND_SPHERE, KIND_RECT: begin
                for (j = 0; j < 3; j++) begin
                    f[j] = widen(data[131 + 32 * j +: 32]);
                    s[j] = widen(data[227 + 32 * j +: 32]);
                end
                // per-axis corner bounds, exact at full width
                for (j = 0; j < 3; j++) begin
                    if (kind == KIND_BOX) begin
                        lo[j] = f[j];
                        hi[j] = s[j];
                    end else if (kind == KIND_CUBE) begin
                        lo[j] = f[j] - s[0];
                        hi[j] = f[j] + s[0];
                    end else begin
                        lo[j] = f[j] - s[j];
                        hi[j] = f[j] + s[j];
                    end
                end
                vis = 1'b1;
                for (i = 0; i < PLANE_COUNT; i++) begin
                    if (kind == KIND_POINT) begin
                        hit = side_ok(i, f[0], f[1], f[2], '0);
                    end else if (kind == KIND_SPHERE) begin
                        hit = side_ok(i, f[0], f[1], f[2], s[0]);
                    end else begin
                        hit = 1'b0;
                        for (k = 0; k < 8; k++) begin
                            hit |= side_ok(i, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                           k[2] ? hi[2] : lo[2], '0);
                        end
                    end
                    vis &= hit;
                end
            end
            default: vis = 1'b0;
        endcase
        return vis;
    endfunction

    // result beats are checked before the same edge's input beat is queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                frustum_planes[p] = '0;
            end
            expected_visible.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_visible.size() == 0) begin
                    errs++;
                    $error("visible: expected none, actual %0b", m_tdata[0]);
                end else begin
                    want = expected_visible.pop_front();
                    if (m_tdata[0] !== want) begin
                        errs++;
                        $error("visible: expected %0b, actual %0b", want, m_tdata[0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_visible.push_back(cull_predict(s_tuser, s_tdata));
            end
        end
        fail_count <= errs;
        pending    <= expected_visible.size();
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives plane loads and bound queries into the frustum visibility test,
// with random gaps and stalls on both channels, and gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fvt_pkg::*;

    localparam int          PLANE_COUNT  = 6;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 2 + 2 * PLANE_COUNT + 16;
    localparam int          HOLD_OFF     = 400;
    localparam logic [2:0]  KIND_SPARE_6 = 3'd6;
    localparam logic [2:0]  KIND_SPARE_7 = 3'd7;
    localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX      = 32'h8000_0000;
    localparam logic [31:0] MINUS_LSB    = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   cycles   = 0;
    logic                 tx_burst = 1'b0;

    frustum_visibility_test #(.PLANE_COUNT(PLANE_COUNT)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fvt_visibility_checker #(.PLANE_COUNT(PLANE_COUNT)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // uniform value in [-half, half]
    function automatic logic [31:0] span(int unsigned half);
        logic [31:0] r;
        r = $urandom_range(0, 2 * half);
        return r - half;
    endfunction

    // object size in q16.16, sometimes negative
    function automatic logic [31:0] extent();
        logic [31:0] r;
        r = $urandom_range(0, 300 << 16);
        if ($urandom_range(0, 9) == 0) begin
            r = -r;
        end
        return r;
    endfunction

    // near axis-aligned plane facing into the view volume for its slot
    function automatic fvt_plane_t frustum_plane(logic [2:0] slot);
        fvt_plane_t  p;
        logic [31:0] unit;
        unit = slot[0] ? -(32'd1 << 30) : (32'd1 << 30);
        p.a  = span(1 << 22);
        p.b  = span(1 << 22);
        p.c  = span(1 << 22);
        p.d  = $urandom_range(1 << 16, 1000 << 16);
        if ($urandom_range(0, 15) == 0) begin
            p.d = -p.d;
        end
        case (slot[2:1])
            2'd0:    p.c = unit;
            2'd2:    p.b = unit;
            default: p.a = unit;
        endcase
        return p;
    endfunction

    function automatic fvt_plane_t random_plane();
        fvt_plane_t p;
        p.a = $urandom;
        p.b = $urandom;
        p.c = $urandom;
        p.d = $urandom;
        return p;
    endfunction

    // load beat: bound fields carry noise
    function automatic logic [S_TDATA_W-1:0] load_data(logic [2:0] slot, fvt_plane_t p);
        return {5'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                p.d, p.c, p.b, p.a, slot};
    endfunction

    // query beat: slot and plane fields carry noise
    function automatic logic [S_TDATA_W-1:0] bound_data(logic [31:0] fx, fy, fz, sx, sy, sz);
        logic [2:0] junk;
        junk = 3'($urandom);
        return {5'b0, sz, sy, sx, fz, fy, fx, $urandom, $urandom, $urandom, $urandom, junk};
    endfunction

    // offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [2:0] kind, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // result side: random stalls, bursts, and two long hold-offs
    initial begin
        int   stall;
        int   got;
        logic rx_burst;
        got      = 0;
        rx_burst = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (got % 64 == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (got == 200 || got == 750) begin
                stall = HOLD_OFF;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            got++;
        end
    end

    // stimulus and verdict
    initial begin
        int          phase;
        int          n;
        int          pick;
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [31:0] fx, fy, fz, sx, sy, sz;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero table: points and boxes pass, spheres pass only with radius >= 0
        send_beat(KIND_POINT, bound_data('0, '0, '0, '0, '0, '0));
        send_beat(KIND_SPHERE, bound_data(POS_MAX, NEG_MAX, '0, MINUS_LSB, '0, '0));
        send_beat(KIND_SPHERE, bound_data(NEG_MAX, POS_MAX, '0, '0, '0, '0));
        send_beat(KIND_BOX, bound_data(NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX));
        // unused kinds leave everything alone
        send_beat(KIND_SPARE_6, bound_data($urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom));
        send_beat(KIND_SPARE_7, bound_data($urandom, $urandom, $urandom, $urandom, $urandom,
                                           $urandom));
        // loads to slots beyond the table are dropped
        send_beat(KIND_LOAD, load_data(3'd6, '{a: POS_MAX, b: POS_MAX, c: POS_MAX, d: NEG_MAX}));
        send_beat(KIND_LOAD, load_data(3'd7, '{a: NEG_MAX, b: NEG_MAX, c: NEG_MAX, d: NEG_MAX}));
        send_beat(KIND_SPHERE, bound_data('0, '0, '0, MINUS_LSB, '0, '0));

        // a proper frustum, then two point queries and one query of each other shape
        for (n = 0; n < PLANE_COUNT; n++) begin
            send_beat(KIND_LOAD, load_data(3'(n), frustum_plane(3'(n))));
        end
        send_beat(KIND_POINT, bound_data('0, '0, '0, '0, '0, '0));
        send_beat(KIND_POINT, bound_data(POS_MAX, '0, '0, '0, '0, '0));
        send_beat(KIND_BOX, bound_data(-(32'd2000 << 16), '0, '0, 32'd2000 << 16, ONE_Q16,
                                       ONE_Q16));
        send_beat(KIND_CUBE, bound_data(32'd1500 << 16, '0, '0, 32'd600 << 16, '0, '0));
        send_beat(KIND_RECT, bound_data('0, 32'd900 << 16, '0, ONE_Q16, 32'd200 << 16,
                                        ONE_Q16));
        send_beat(KIND_SPHERE, bound_data(32'd1001 << 16, '0, '0, 32'd2 << 16, '0, '0));

        // extreme normals and coordinates stress the full product width
        send_beat(KIND_LOAD, load_data(3'd0, '{a: NEG_MAX, b: NEG_MAX, c: NEG_MAX, d: NEG_MAX}));
        send_beat(KIND_POINT, bound_data(NEG_MAX, NEG_MAX, NEG_MAX, '0, '0, '0));
        send_beat(KIND_CUBE, bound_data(POS_MAX, POS_MAX, POS_MAX, NEG_MAX, '0, '0));
        send_beat(KIND_RECT, bound_data(POS_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_beat(KIND_LOAD, load_data(3'd5, '{a: POS_MAX, b: POS_MAX, c: POS_MAX, d: POS_MAX}));
        send_beat(KIND_SPHERE, bound_data(NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, '0, '0));
        // swapped box bounds are put back in order per axis by the front end
        send_beat(KIND_BOX, bound_data(POS_MAX, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX));

        // random phases: fresh table each phase, then mostly queries
        for (phase = 0; phase < 10; phase++) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 3);
            for (n = 0; n < PLANE_COUNT; n++) begin
                send_beat(KIND_LOAD, load_data(3'(n), (pick != 0) ? frustum_plane(3'(n))
                                                                  : random_plane()));
            end
            for (n = 0; n < 104; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    slot = 3'($urandom_range(0, 7));
                    send_beat(KIND_LOAD, load_data(slot, pick[0] ? frustum_plane(slot)
                                                                 : random_plane()));
                end else if (pick < 12) begin
                    send_beat(pick[0] ? KIND_SPARE_7 : KIND_SPARE_6,
                              bound_data($urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom));
                end else begin
                    kind = 3'($urandom_range(KIND_POINT, KIND_RECT));
                    if (pick < 30) begin
                        fx = $urandom; fy = $urandom; fz = $urandom;
                        sx = $urandom; sy = $urandom; sz = $urandom;
                    end else begin
                        fx = span(1200 << 16); fy = span(1200 << 16); fz = span(1200 << 16);
                        sx = extent(); sy = extent(); sz = extent();
                        // box maximum relative to its minimum
                        if (kind == KIND_BOX) begin
                            sx = fx + sx; sy = fy + sy; sz = fz + sz;
                        end
                    end
                    send_beat(kind, bound_data(fx, fy, fz, sx, sy, sz));
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain the chain, then give it time to show any stray beat
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
